// File: hdl/cama_pkg.sv
// cama_pkg: shared types and constants for the circular angle moving average
// holds the sequencer state type, angle constants, register indexes and side codes
// no dependencies

package cama_pkg;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRAP,
		ST_DIST,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	// angles in 1/64 degree
	localparam logic [16:0] FULL_TURN = 17'd23040;
	localparam logic [16:0] HALF_TURN = 17'd11520;
	// three full turns, makes any heading plus offset positive
	localparam logic [17:0] WRAP_BIAS = 18'd69120;

	// register indexes
	localparam logic REG_AOA_OFFSET    = 1'b0;
	localparam logic REG_WINDOW_LENGTH = 1'b1;

	// register reset values
	localparam logic [13:0] AOA_RESET    = 14'd960;
	localparam logic [7:0]  WINDOW_RESET = 8'd10;

	// tail side codes
	localparam logic [1:0] SIDE_ZERO = 2'b00;
	localparam logic [1:0] SIDE_POS  = 2'b01;
	localparam logic [1:0] SIDE_DBL  = 2'b10;
	localparam logic [1:0] SIDE_NEG  = 2'b11;

	// step counts of the serial phases, loaded as count minus one
	localparam logic [4:0] WRAP_STEPS = 5'd2;
	localparam logic [4:0] MUL_STEPS  = 5'd7;
	localparam logic [4:0] DIV_STEPS  = 5'd23;

endpackage

// File: hdl/circular_angle_moving_average.sv
// circular_angle_moving_average: top level of the wind angle running average
// serial sequencer with a shift-add multiplier and a restoring divider
// depends on cama_pkg

// One word in, one word out. Each input word gives a wing heading and a tail
// side; the block forms the raw wind angle (heading plus angle of attack times
// side, wrapped to one turn), moves the stored average toward it by the
// shortest circular distance, and returns the new average, all in 1/64 degree.
// A word passes from acceptance to the result register through turn
// reduction by four, two and one full turns, the circular distance, a
// shift-add multiply by the sample count (one count bit a cycle), restoring
// division by the count (one quotient bit a cycle) and a final wrap and
// store. A new word is taken only after the last one is stored and the
// sequencer is back in idle. One word is in work at a time; input ready is
// high only while the sequencer is idle. The result sits in an output
// register, so the next word is taken and worked on while the last result
// waits; the sequencer holds in its final step only if that register is
// still full. Configuration writes take effect at once and are meant to be
// made while the block is idle.

module circular_angle_moving_average (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [13:0] cfg_data,
	// input words
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] wing_heading,
	input  logic [1:0]  tail_side,
	// result words
	output logic        out_valid,
	input  logic        out_ready,
	output logic [14:0] wind_direction
);

	// one conditional add or subtract of a full turn, input in (-turn, 2 turns)
	function automatic logic [14:0] wrap_once(input logic [16:0] v);
		logic [16:0] r;
		begin
			if (v[16]) begin
				r = v + cama_pkg::FULL_TURN;
			end else if (v >= cama_pkg::FULL_TURN) begin
				r = v - cama_pkg::FULL_TURN;
			end else begin
				r = v;
			end
			wrap_once = r[14:0];
		end
	endfunction

	cama_pkg::state_t state_q, state_d;

	// configuration registers
	logic [13:0] aoa_q;
	logic [7:0]  window_q;

	// state carried between words
	logic [14:0] avg_q;
	logic [7:0]  count_q;

	// serial datapath
	logic [4:0]  step_q;
	logic [16:0] wrap_q;   // raw angle during turn reduction
	logic [24:0] acc_q;    // product accumulator, two's complement
	logic [23:0] md_q;     // multiplicand, shifts left
	logic [7:0]  mq_q;     // multiplier bits, shift right
	logic [23:0] num_q;    // dividend in, quotient out
	logic [7:0]  rem_q;    // partial remainder

	// output register
	logic        out_valid_q;
	logic [14:0] out_q;

	logic        accept;
	logic        fin_load;
	logic        last_step;

	// raw angle at acceptance
	logic [17:0] heading_ext;
	logic [17:0] aoa_ext;
	logic [17:0] off_ext;
	logic [17:0] raw_sum;

	// turn reduction
	logic [16:0] wrap_sub_const;
	logic [17:0] wrap_diff;

	// circular distance
	logic [16:0] dist_raw;
	logic [14:0] dist_wrapped;
	logic [16:0] dist_signed;

	// multiply and divide steps
	logic [24:0] acc_sum;
	logic [24:0] acc_next;
	logic [8:0]  div_trial;
	logic [9:0]  div_diff;
	logic        div_bit;

	// final wrap
	logic [16:0] fin_raw;
	logic [14:0] fin_angle;

	logic [7:0]  count_next;

	assign in_ready       = (state_q == cama_pkg::ST_IDLE);
	assign accept         = in_valid && in_ready;
	assign out_valid      = out_valid_q;
	assign wind_direction = out_q;
	assign last_step      = (step_q == 5'd0);

	// heading plus side times offset, biased positive
	assign heading_ext = {{2{wing_heading[15]}}, wing_heading};
	assign aoa_ext     = {{4{aoa_q[13]}}, aoa_q};

	always_comb begin
		case (tail_side)
			cama_pkg::SIDE_POS: off_ext = aoa_ext;
			cama_pkg::SIDE_NEG: off_ext = 18'd0 - aoa_ext;
			cama_pkg::SIDE_DBL: off_ext = 18'd0 - {aoa_ext[16:0], 1'b0};
			default:            off_ext = 18'd0;
		endcase
	end

	assign raw_sum = heading_ext + off_ext + cama_pkg::WRAP_BIAS;

	// restoring reduction by four, two and one full turns
	always_comb begin
		case (step_q[1:0])
			2'd2:    wrap_sub_const = {cama_pkg::FULL_TURN[14:0], 2'b00};
			2'd1:    wrap_sub_const = {cama_pkg::FULL_TURN[15:0], 1'b0};
			default: wrap_sub_const = cama_pkg::FULL_TURN;
		endcase
	end

	assign wrap_diff = {1'b0, wrap_q} - {1'b0, wrap_sub_const};

	// shortest signed distance from the average, in [-half, half)
	assign dist_raw     = {2'b00, wrap_q[14:0]} + cama_pkg::HALF_TURN - {2'b00, avg_q};
	assign dist_wrapped = wrap_once(dist_raw);
	assign dist_signed  = {2'b00, dist_wrapped} - cama_pkg::HALF_TURN;

	// shift-add step: acc += (avg + half) * count, one count bit a cycle
	assign acc_sum  = acc_q + {1'b0, md_q};
	assign acc_next = mq_q[0] ? acc_sum : acc_q;

	// restoring division step, one quotient bit a cycle
	assign div_trial = {rem_q, num_q[23]};
	assign div_diff  = {1'b0, div_trial} - {2'b00, count_q};
	assign div_bit   = !div_diff[9];

	// quotient is biased by half a turn, which keeps the dividend positive
	assign fin_raw   = {1'b0, num_q[15:0]} - cama_pkg::HALF_TURN;
	assign fin_angle = wrap_once(fin_raw);

	// count climbs toward the window; its next value is never below one
	always_comb begin
		count_next = count_q;
		if (count_q < window_q) begin
			count_next = count_q + 8'd1;
		end
		if (count_next == 8'd0) begin
			count_next = 8'd1;
		end
	end

	// next state
	always_comb begin
		state_d  = state_q;
		fin_load = 1'b0;
		unique case (state_q)
			cama_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = cama_pkg::ST_WRAP;
				end
			end
			cama_pkg::ST_WRAP: begin
				if (last_step) begin
					state_d = cama_pkg::ST_DIST;
				end
			end
			cama_pkg::ST_DIST: begin
				state_d = cama_pkg::ST_MUL;
			end
			cama_pkg::ST_MUL: begin
				if (last_step) begin
					state_d = cama_pkg::ST_DIV;
				end
			end
			cama_pkg::ST_DIV: begin
				if (last_step) begin
					state_d = cama_pkg::ST_FIN;
				end
			end
			cama_pkg::ST_FIN: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					fin_load = 1'b1;
					state_d  = cama_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cama_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cama_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aoa_q    <= cama_pkg::AOA_RESET;
			window_q <= cama_pkg::WINDOW_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cama_pkg::REG_AOA_OFFSET:    aoa_q    <= cfg_data;
				cama_pkg::REG_WINDOW_LENGTH: window_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// average, sample count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q       <= 15'd0;
			count_q     <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
			end
			if (fin_load) begin
				avg_q       <= fin_angle;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_q <= fin_angle;
		end
	end

	// serial datapath
	always_ff @(posedge clk) begin
		case (state_q)
			cama_pkg::ST_IDLE: begin
				wrap_q <= raw_sum[16:0];
				step_q <= cama_pkg::WRAP_STEPS;
			end
			cama_pkg::ST_WRAP: begin
				if (!wrap_diff[17]) begin
					wrap_q <= wrap_diff[16:0];
				end
				step_q <= step_q - 5'd1;
			end
			cama_pkg::ST_DIST: begin
				acc_q  <= {{8{dist_signed[16]}}, dist_signed};
				// average plus half a turn reaches above 15 bits
				md_q   <= {8'd0, 16'({1'b0, avg_q} + cama_pkg::HALF_TURN[15:0])};
				mq_q   <= count_q;
				step_q <= cama_pkg::MUL_STEPS;
			end
			cama_pkg::ST_MUL: begin
				acc_q <= acc_next;
				md_q  <= {md_q[22:0], 1'b0};
				mq_q  <= {1'b0, mq_q[7:1]};
				if (last_step) begin
					num_q  <= acc_next[23:0];
					rem_q  <= 8'd0;
					step_q <= cama_pkg::DIV_STEPS;
				end else begin
					step_q <= step_q - 5'd1;
				end
			end
			cama_pkg::ST_DIV: begin
				rem_q  <= div_bit ? div_diff[7:0] : div_trial[7:0];
				num_q  <= {num_q[22:0], div_bit};
				step_q <= step_q - 5'd1;
			end
			default: ;
		endcase
	end

	// the stored average never leaves one turn
	a_avg_in_turn: assert property (@(posedge clk) disable iff (!arst_n)
		{2'b00, avg_q} < cama_pkg::FULL_TURN)
		else $error("average left the turn range");

	// a presented result is a wrapped angle
	a_out_in_turn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {2'b00, wind_direction} < cama_pkg::FULL_TURN)
		else $error("result angle out of range");

	// the divisor is never zero while a word is in work
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != cama_pkg::ST_IDLE) |-> (count_q != 8'd0))
		else $error("sample count zero during work");

	// partial remainder stays below the divisor
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cama_pkg::ST_DIV) |-> (rem_q < count_q))
		else $error("divider remainder not below count");

	// the final step does not overwrite a waiting result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cama_pkg::ST_FIN && out_valid && !out_ready)
		|=> (state_q == cama_pkg::ST_FIN))
		else $error("result overwritten while waiting");

endmodule
